### sv/lav_pkg.sv
package lav_pkg;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col_0;
        logic signed [31:0] col_1;
        logic signed [31:0] col_2;
        logic signed [31:0] col_3;
        logic               clipped;
        logic               last_row;
    } row_t;

    // One vector job for the back end: components (Q4.28 max range) and position.
    typedef struct packed {
        logic [1:0]         row;
        logic signed [32:0] c0;
        logic signed [32:0] c1;
        logic signed [32:0] c2;
        logic               neg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } job_t;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_GAZE = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic signed [31:0] Q16_ONE = 32'sd65536;

endpackage

### sv/lav_front.sv
module lav_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lav_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             job_valid,
    output lav_pkg::job_t    job,
    input  logic             job_ready
);

    logic                busy_reg, busy_next;
    logic [1:0]          phase_reg, phase_next;
    lav_pkg::cmd_t       cmd_reg;
    logic signed [31:0]  prod_a_reg [3];
    logic signed [31:0]  prod_b_reg [3];
    logic                prod_ok_reg, prod_ok_next;

    assign busy = busy_reg;

    // Cross product terms are registered from the captured command after accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= '0;
            prod_ok_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            prod_ok_reg <= prod_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
            cmd_reg <= cmd;
        if (busy_reg && !prod_ok_reg)
        begin
            prod_a_reg[0] <= cmd_reg.rot_12 * cmd_reg.rot_21;
            prod_b_reg[0] <= cmd_reg.rot_22 * cmd_reg.rot_11;
            prod_a_reg[1] <= cmd_reg.rot_22 * cmd_reg.rot_01;
            prod_b_reg[1] <= cmd_reg.rot_02 * cmd_reg.rot_21;
            prod_a_reg[2] <= cmd_reg.rot_02 * cmd_reg.rot_11;
            prod_b_reg[2] <= cmd_reg.rot_12 * cmd_reg.rot_01;
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        phase_next   = phase_reg;
        prod_ok_next = prod_ok_reg;
        job_valid    = busy_reg && prod_ok_reg;
        job.px       = cmd_reg.pos_x;
        job.py       = cmd_reg.pos_y;
        job.pz       = cmd_reg.pos_z;
        job.row      = phase_reg;
        job.neg      = 1'b0;
        job.c0       = '0;
        job.c1       = '0;
        job.c2       = '0;
        unique case (phase_reg)
            lav_pkg::ROW_SIDE:
            begin
                job.c0 = 33'(prod_a_reg[0]) - 33'(prod_b_reg[0]);
                job.c1 = 33'(prod_a_reg[1]) - 33'(prod_b_reg[1]);
                job.c2 = 33'(prod_a_reg[2]) - 33'(prod_b_reg[2]);
            end
            lav_pkg::ROW_UP:
            begin
                job.c0 = 33'(cmd_reg.rot_01);
                job.c1 = 33'(cmd_reg.rot_11);
                job.c2 = 33'(cmd_reg.rot_21);
            end
            lav_pkg::ROW_GAZE:
            begin
                job.neg = 1'b1;
                job.c0  = 33'(cmd_reg.rot_02);
                job.c1  = 33'(cmd_reg.rot_12);
                job.c2  = 33'(cmd_reg.rot_22);
            end
            default:
            begin
                job.c0 = '0;
            end
        endcase
        if (start && !busy_reg)
        begin
            busy_next    = 1'b1;
            phase_next   = lav_pkg::ROW_SIDE;
            prod_ok_next = 1'b0;
        end
        else if (busy_reg && !prod_ok_reg)
            prod_ok_next = 1'b1;
        else if (job_valid && job_ready)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == lav_pkg::ROW_LAST)
                busy_next = 1'b0;
        end
    end

endmodule

### sv/lav_queue.sv
module lav_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  lav_pkg::job_t in_job,
    output logic          in_ready,
    output logic          out_valid,
    output lav_pkg::job_t out_job,
    input  logic          out_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lav_pkg::job_t     mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    logic              push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_job   = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_job;
    end

endmodule

### sv/lav_back.sv
module lav_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  lav_pkg::job_t job,
    output logic          job_ready,
    output logic          result_valid,
    output lav_pkg::row_t result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DOT  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    lav_pkg::job_t       job_reg;
    logic [1:0]          idx_reg;
    logic [63:0]         l2_reg;
    logic [5:0]          sh_reg;
    logic [63:0]         n_reg, res_reg, bit_reg;
    logic [5:0]          cnt_reg;
    logic [32:0]         mag_reg [3];
    logic [95:0]         num_reg, den_reg;
    logic [16:0]         q_reg;
    logic signed [31:0]  nv_reg [3];
    logic [63:0]         sq_reg [3];
    logic signed [95:0]  acc_reg;
    logic [1:0]          dpart_reg;

    logic [32:0]         mag_c;
    logic [63:0]         l2s;
    logic [64:0]         trial;
    logic [96:0]         dtrial;
    logic signed [63:0]  pprod;
    logic signed [31:0]  pos_sel;
    logic signed [95:0]  tnum;
    logic signed [79:0]  tval;
    logic                tclip;
    logic signed [31:0]  tsat;

    assign job_ready = state_reg == S_IDLE;

    function automatic logic [32:0] absv(input logic signed [32:0] v);
        absv = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signs(input logic [1:0] i);
        logic signed [32:0] c;
        c = (i == 2'd0) ? job_reg.c0 : (i == 2'd1) ? job_reg.c1 : job_reg.c2;
        signs = c[32];
    endfunction

    always_comb
    begin
        mag_c   = mag_reg[idx_reg];
        l2s     = l2_reg << sh_reg;
        trial   = {1'b0, res_reg} + {1'b0, bit_reg};
        dtrial  = {1'b0, num_reg} - {1'b0, den_reg};
        pos_sel = (idx_reg == 2'd0) ? job_reg.px :
                  (idx_reg == 2'd1) ? job_reg.py : job_reg.pz;
        pprod   = nv_reg[idx_reg] * pos_sel;
        tnum    = -acc_reg + 96'sd32768;
        tval    = 80'(tnum >>> 16);
        tclip   = (tval > 80'sd2147483647) || (tval < -80'sd2147483648);
        tsat    = (tval > 80'sd2147483647) ? 32'sh7fffffff :
                  (tval < -80'sd2147483648) ? 32'sh80000000 : tval[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (job_valid) state_next = (job.row == lav_pkg::ROW_LAST) ? S_OUT : S_SQR;
            S_SQR:  if (idx_reg == 2'd2) state_next = S_NORM;
            S_NORM:
            begin
                if (idx_reg == 2'd3)
                    state_next = S_NORM;
                else if (l2_reg == '0)
                    state_next = S_OUT;
                else if (sh_reg >= 6'd62 || (l2s << 2) >= 64'h4000_0000_0000_0000
                         || l2s[63:62] != 2'b00)
                    state_next = S_SQRT;
            end
            S_SQRT: if (cnt_reg == 6'd31) state_next = S_DIV;
            S_DIV:  if (cnt_reg == 6'd17 && idx_reg == 2'd2) state_next = S_DOT;
            S_DOT:  if (dpart_reg == 2'd1 && idx_reg == 2'd2) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg    <= job;
                idx_reg    <= '0;
                l2_reg     <= '0;
                sh_reg     <= '0;
                acc_reg    <= '0;
                dpart_reg  <= '0;
                mag_reg[0] <= absv(job.c0);
                mag_reg[1] <= absv(job.c1);
                mag_reg[2] <= absv(job.c2);
                nv_reg[0]  <= '0;
                nv_reg[1]  <= '0;
                nv_reg[2]  <= '0;
            end
            S_SQR:
            begin
                sq_reg[idx_reg] <= mag_c[31:0] * mag_c[31:0];
                if (idx_reg != 2'd0)
                    l2_reg <= l2_reg + sq_reg[idx_reg - 2'd1];
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                    idx_reg <= 2'd3;
            end
            S_NORM:
            begin
                if (idx_reg == 2'd3)
                begin
                    l2_reg  <= l2_reg + sq_reg[2];
                    idx_reg <= 2'd0;
                end
                else if (state_next == S_SQRT)
                begin
                    n_reg   <= l2s;
                    res_reg <= '0;
                    bit_reg <= 64'h4000_0000_0000_0000;
                    cnt_reg <= '0;
                end
                else
                    sh_reg <= sh_reg + 6'd2;
            end
            S_SQRT:
            begin
                if (n_reg >= trial[63:0])
                begin
                    n_reg   <= n_reg - trial[63:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_reg <= '0;
                    idx_reg <= '0;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    num_reg <= ({63'd0, mag_c} << (6'd17 + sh_reg[5:1])) + 96'(res_reg);
                    den_reg <= 96'(res_reg) << 17;
                    q_reg   <= '0;
                    cnt_reg <= 6'd1;
                end
                else
                begin
                    if (!dtrial[96])
                        num_reg <= dtrial[95:0];
                    q_reg   <= {q_reg[15:0], ~dtrial[96]};
                    den_reg <= den_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd17)
                    begin
                        nv_reg[idx_reg] <= (job_reg.neg ^ signs(idx_reg)) ?
                            -32'(signed'({15'd0, q_reg[15:0], ~dtrial[96]}))
                            : 32'({15'd0, q_reg[15:0], ~dtrial[96]});
                        cnt_reg <= '0;
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd2)
                            idx_reg <= '0;
                    end
                end
            end
            S_DOT:
            begin
                if (dpart_reg == 2'd0)
                begin
                    sq_reg[0] <= 64'(pprod);
                    dpart_reg <= 2'd1;
                end
                else
                begin
                    acc_reg   <= acc_reg + 96'(signed'(sq_reg[0]));
                    dpart_reg <= 2'd0;
                    idx_reg   <= idx_reg + 2'd1;
                end
            end
            S_OUT:
            begin
                idx_reg <= '0;
            end
            default:
            begin
                idx_reg <= '0;
            end
        endcase
    end

    always_comb
    begin
        result_valid     = state_reg == S_OUT;
        result.row_index = job_reg.row;
        result.last_row  = job_reg.row == lav_pkg::ROW_LAST;
        if (job_reg.row == lav_pkg::ROW_LAST)
        begin
            result.col_0   = '0;
            result.col_1   = '0;
            result.col_2   = '0;
            result.col_3   = lav_pkg::Q16_ONE;
            result.clipped = 1'b0;
        end
        else
        begin
            result.col_0   = nv_reg[0];
            result.col_1   = nv_reg[1];
            result.col_2   = nv_reg[2];
            result.col_3   = tsat;
            result.clipped = tclip;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && job_valid) |=> state_reg != S_IDLE)
        else $error("job taken but back end idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && job_reg.row == lav_pkg::ROW_LAST) |-> !result.clipped)
        else $error("constant row clipped");

endmodule

### sv/look_at_view_matrix.sv
// Channel  | Direction | Handshake          | Payload
// command  | in        | start, busy        | cmd (lav_pkg::cmd_t)
// result   | out       | done strobe        | result (lav_pkg::row_t)
// Each transaction yields four result rows in order 0..3, row 3 marked last_row.
// Rows 0..2 each use the shared square root and divider of the back end, their time
// set by the normalizing shift search; a zero-length row skips both. Row 3 goes straight
// to output. busy falls after the last row is queued. Reset clears all control state but
// the back-end counters. The receiver cannot stall: each strobe lasts one cycle.
module look_at_view_matrix #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lav_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done,
    output lav_pkg::row_t  result
);

    logic          f_valid, f_ready, q_valid, q_ready;
    lav_pkg::job_t f_job, q_job;

    lav_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    lav_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_job(f_job),
        .in_ready(f_ready), .out_valid(q_valid), .out_job(q_job), .out_ready(q_ready)
    );

    lav_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_job),
        .job_ready(q_ready), .result_valid(done), .result(result)
    );

endmodule
